FILE: rtl/core/ldsk_pkg.sv
// shared types and constants for the serial led driver with key scan
// no dependencies; used by every module under rtl/core except ldsk_ram
`default_nettype none

package ldsk_pkg;

    localparam int RAM_DEPTH_DEF  = 14;
    localparam int GRID_COUNT_DEF = 4;

    localparam int BYTE_W     = 8;
    localparam int BCNT_W     = 5;
    localparam int WADDR_W    = 4;
    localparam int RADDR_W    = 5;
    localparam int GRID_W     = 3;
    localparam int GRID_LINES = 4;
    localparam int KEY_W      = 5;
    localparam int KBITS_W    = 24;

    // event kinds on the input side
    localparam logic [1:0] EV_STROBE = 2'd0;
    localparam logic [1:0] EV_CLK_RISE = 2'd1;
    localparam logic [1:0] EV_CLK_FALL = 2'd2;
    localparam logic [1:0] EV_TICK = 2'd3;

    // command classes, top two bits of the first byte
    localparam logic [1:0] CMD_MODE = 2'b00;
    localparam logic [1:0] CMD_DATA = 2'b01;
    localparam logic [1:0] CMD_CTRL = 2'b10;
    localparam logic [1:0] CMD_ADDR = 2'b11;

    // pin operation carried to the pin stage
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_SCAN = 2'd1;
    localparam logic [1:0] OP_REFRESH = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [GRID_W-1:0] grid;
        logic              even_ok;
        logic              odd_ok;
        logic              dio_drive;
        logic              dio_level;
    } t_pin_req;

endpackage

`default_nettype wire

FILE: rtl/core/ldsk_ram.sv
// generic ram: one write port, two registered read ports
// no dependencies
`default_nettype none

module ldsk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/ldsk_ctrl.sv
// serial receiver, command decoder, key readout and refresh sequencing
// depends on ldsk_pkg; drives the display ram write and read ports
`default_nettype none

module ldsk_ctrl #(
    parameter int RAM_DEPTH  = ldsk_pkg::RAM_DEPTH_DEF,
    parameter int GRID_COUNT = ldsk_pkg::GRID_COUNT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic [1:0]                    i_kind,
    input  wire logic                          i_dio,
    input  wire logic [ldsk_pkg::KEY_W-1:0]    i_keys,
    output logic                               o_we,
    output logic [$clog2(RAM_DEPTH)-1:0]       o_waddr,
    output logic [ldsk_pkg::BYTE_W-1:0]        o_wdata,
    output logic                               o_re,
    output logic [$clog2(RAM_DEPTH)-1:0]       o_raddr_even,
    output logic [$clog2(RAM_DEPTH)-1:0]       o_raddr_odd,
    output ldsk_pkg::t_pin_req                 o_req
);

    localparam int AW = $clog2(RAM_DEPTH);
    localparam int GW = (GRID_COUNT > 1) ? $clog2(GRID_COUNT) : 1;

    logic [ldsk_pkg::BYTE_W-1:0]  r_shift, n_shift;
    logic [ldsk_pkg::BCNT_W-1:0]  r_bcnt, n_bcnt;
    logic [ldsk_pkg::WADDR_W-1:0] r_waddr, n_waddr;
    logic                         r_auto, n_auto;
    logic                         r_disp_en, n_disp_en;
    logic [GW-1:0]                r_grid, n_grid;
    logic                         r_expect, n_expect;
    logic                         r_readout, n_readout;
    logic [ldsk_pkg::KBITS_W-1:0] r_kbits, n_kbits;
    logic                         r_phase, n_phase;
    logic                         r_dio_lvl, n_dio_lvl;
    logic                         r_dio_drv, n_dio_drv;
    logic [RAM_DEPTH-1:0]         r_vld, n_vld;

    logic [ldsk_pkg::RADDR_W-1:0] w_addr_even;
    logic [ldsk_pkg::RADDR_W-1:0] w_addr_odd;

    assign w_addr_even = {ldsk_pkg::RADDR_W'({{(ldsk_pkg::GRID_W-GW){1'b0}}, r_grid}) << 1};
    assign w_addr_odd  = w_addr_even | ldsk_pkg::RADDR_W'(1);
    assign o_raddr_even = w_addr_even[AW-1:0];
    assign o_raddr_odd  = w_addr_odd[AW-1:0];

    always_comb begin
        logic [ldsk_pkg::BYTE_W-1:0] v_byte;
        logic [ldsk_pkg::BCNT_W-1:0] v_cnt;
        logic [4:0]                  v_inc;

        n_shift   = r_shift;
        n_bcnt    = r_bcnt;
        n_waddr   = r_waddr;
        n_auto    = r_auto;
        n_disp_en = r_disp_en;
        n_grid    = r_grid;
        n_expect  = r_expect;
        n_readout = r_readout;
        n_kbits   = r_kbits;
        n_phase   = r_phase;
        n_dio_lvl = r_dio_lvl;
        n_dio_drv = r_dio_drv;
        n_vld     = r_vld;
        o_we      = 1'b0;
        o_waddr   = r_waddr[AW-1:0];
        o_wdata   = '0;
        o_re      = 1'b0;
        o_req.op  = ldsk_pkg::OP_NONE;
        v_byte    = r_shift;
        v_cnt     = r_bcnt;
        v_inc     = 5'(r_waddr) + 5'd1;

        if (i_accept) begin
            unique case (i_kind)
                ldsk_pkg::EV_STROBE: begin
                    n_bcnt    = '0;
                    n_shift   = '0;
                    n_expect  = 1'b1;
                    n_readout = 1'b0;
                    n_dio_drv = 1'b0;
                end
                ldsk_pkg::EV_CLK_RISE: begin
                    if (!r_readout) begin
                        v_byte = r_shift;
                        v_byte[r_bcnt[2:0]] = r_shift[r_bcnt[2:0]] | i_dio;
                        v_cnt  = r_bcnt + ldsk_pkg::BCNT_W'(1);
                        n_shift = v_byte;
                        n_bcnt  = v_cnt;
                        if (v_cnt >= ldsk_pkg::BCNT_W'(8)) begin
                            n_shift = '0;
                            n_bcnt  = '0;
                            if (!r_expect) begin
                                // data byte into display ram
                                if (5'(r_waddr) < 5'(RAM_DEPTH)) begin
                                    o_we    = 1'b1;
                                    o_wdata = v_byte;
                                    n_vld[r_waddr[AW-1:0]] = 1'b1;
                                    if (r_auto) begin
                                        n_waddr = (v_inc >= 5'(RAM_DEPTH)) ? '0 : v_inc[3:0];
                                    end
                                end
                            end else begin
                                unique case (v_byte[7:6])
                                    ldsk_pkg::CMD_DATA: begin
                                        if (v_byte[1]) begin
                                            n_readout = 1'b1;
                                            n_dio_drv = 1'b1;
                                        end
                                        n_auto   = !v_byte[2];
                                        n_expect = 1'b0;
                                    end
                                    ldsk_pkg::CMD_ADDR: begin
                                        n_waddr  = v_byte[3:0];
                                        n_expect = 1'b0;
                                    end
                                    ldsk_pkg::CMD_CTRL: begin
                                        n_disp_en = v_byte[3];
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                        end
                    end
                end
                ldsk_pkg::EV_CLK_FALL: begin
                    if (r_readout && r_bcnt < ldsk_pkg::BCNT_W'(ldsk_pkg::KBITS_W)) begin
                        n_dio_lvl = r_kbits[r_bcnt];
                        n_bcnt    = r_bcnt + ldsk_pkg::BCNT_W'(1);
                    end
                end
                ldsk_pkg::EV_TICK: begin
                    if (r_phase) begin
                        // key scan: KS1..KS5 land at bits 1, 4, 9, 12, 17
                        n_kbits     = '0;
                        n_kbits[1]  = i_keys[0];
                        n_kbits[4]  = i_keys[1];
                        n_kbits[9]  = i_keys[2];
                        n_kbits[12] = i_keys[3];
                        n_kbits[17] = i_keys[4];
                        n_phase     = 1'b0;
                        o_req.op    = ldsk_pkg::OP_SCAN;
                    end else begin
                        n_phase = 1'b1;
                        if (r_disp_en) begin
                            o_re     = 1'b1;
                            o_req.op = ldsk_pkg::OP_REFRESH;
                            n_grid   = (32'(r_grid) == GRID_COUNT - 1) ? '0 : r_grid + GW'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        o_req.grid      = ldsk_pkg::GRID_W'(r_grid);
        o_req.even_ok   = (w_addr_even < ldsk_pkg::RADDR_W'(RAM_DEPTH)) && r_vld[o_raddr_even];
        o_req.odd_ok    = (w_addr_odd < ldsk_pkg::RADDR_W'(RAM_DEPTH)) && r_vld[o_raddr_odd];
        o_req.dio_drive = n_dio_drv;
        o_req.dio_level = n_dio_lvl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift   <= '0;
            r_bcnt    <= '0;
            r_waddr   <= '0;
            r_auto    <= 1'b0;
            r_disp_en <= 1'b0;
            r_grid    <= '0;
            r_expect  <= 1'b1;
            r_readout <= 1'b0;
            r_kbits   <= '0;
            r_phase   <= 1'b0;
            r_dio_lvl <= 1'b0;
            r_dio_drv <= 1'b0;
            r_vld     <= '0;
        end else begin
            r_shift   <= n_shift;
            r_bcnt    <= n_bcnt;
            r_waddr   <= n_waddr;
            r_auto    <= n_auto;
            r_disp_en <= n_disp_en;
            r_grid    <= n_grid;
            r_expect  <= n_expect;
            r_readout <= n_readout;
            r_kbits   <= n_kbits;
            r_phase   <= n_phase;
            r_dio_lvl <= n_dio_lvl;
            r_dio_drv <= n_dio_drv;
            r_vld     <= n_vld;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/ldsk_pins.sv
// pin stage: builds segment and grid levels from ram data, holds the output word
// depends on ldsk_pkg; takes requests from ldsk_ctrl and read data from the ram
`default_nettype none

module ldsk_pins (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_accept,
    input  wire ldsk_pkg::t_pin_req          i_req,
    input  wire logic [ldsk_pkg::BYTE_W-1:0] i_rdata_even,
    input  wire logic [ldsk_pkg::BYTE_W-1:0] i_rdata_odd,
    input  wire logic                        i_out_ready,
    output logic                             o_in_ready,
    output logic                             o_out_valid,
    output logic                             o_dio_drive,
    output logic                             o_dio_out,
    output logic [ldsk_pkg::BYTE_W-1:0]      o_seg,
    output logic [ldsk_pkg::GRID_LINES-1:0]  o_grid
);

    logic                          r_s1_valid;
    ldsk_pkg::t_pin_req            r_s1_req;
    logic                          r_out_valid;
    logic                          r_dio_drv;
    logic                          r_dio_lvl;
    logic [ldsk_pkg::BYTE_W-1:0]   r_seg, n_seg;
    logic [ldsk_pkg::GRID_LINES-1:0] r_grid, n_grid;
    logic                          w_s1_adv;
    logic [ldsk_pkg::BYTE_W-1:0]   w_even;
    logic [ldsk_pkg::BYTE_W-1:0]   w_odd;

    assign w_s1_adv   = r_s1_valid && (!r_out_valid || i_out_ready);
    // no word taken while reset is held
    assign o_in_ready = i_rst_n && (!r_s1_valid || w_s1_adv);

    // entries never written read as zero
    assign w_even = r_s1_req.even_ok ? i_rdata_even : '0;
    assign w_odd  = r_s1_req.odd_ok ? i_rdata_odd : '0;

    always_comb begin
        n_seg  = r_seg;
        n_grid = r_grid;
        case (r_s1_req.op)
            ldsk_pkg::OP_SCAN: begin
                n_grid = '1;
                n_seg  = {r_seg[7:5], 5'b01111};
            end
            ldsk_pkg::OP_REFRESH: begin
                // 5+3 mapping: low five bits of the even byte, bits 5:3 of the odd byte
                n_seg = {w_odd[5:3], w_even[4:0]};
                for (int i = 0; i < ldsk_pkg::GRID_LINES; i++) begin
                    n_grid[i] = r_grid[i] && (r_s1_req.grid != ldsk_pkg::GRID_W'(i));
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_dio_drv   <= 1'b0;
            r_dio_lvl   <= 1'b0;
            r_seg       <= '0;
            r_grid      <= '1;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_accept;
            end
            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
                r_dio_drv   <= r_s1_req.dio_drive;
                r_dio_lvl   <= r_s1_req.dio_level;
                r_seg       <= n_seg;
                r_grid      <= n_grid;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_accept) begin
            r_s1_req <= i_req;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_dio_drive = r_dio_drv;
    assign o_dio_out   = r_dio_lvl;
    assign o_seg       = r_seg;
    assign o_grid      = r_grid;

endmodule

`default_nettype wire

FILE: rtl/core/led_driver_serial_keyscan.sv
// led driver with three-wire serial port and key scan: one pin event per word in,
// one pin-state word out. each word passes the registered display ram read and the
// pin stage output register. throughput: one word per cycle while the output is not stalled.
// reset (synchronous, active low) clears control state: display off, grids high,
// command expected, tready low; display ram entries read as zero until written.
// depends on ldsk_pkg, ldsk_ram, ldsk_ctrl, ldsk_pins
`default_nettype none

module led_driver_serial_keyscan #(
    parameter int RAM_DEPTH  = ldsk_pkg::RAM_DEPTH_DEF,
    parameter int GRID_COUNT = ldsk_pkg::GRID_COUNT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,  // dio_in [0], key_lines [5:1], zero [7:6]
    input  wire logic [1:0]  i_s_axis_tuser,  // kind [1:0]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata   // dio_drive [0], dio_out [1], seg_levels [9:2],
                                              // grid_levels [13:10], zero [15:14]
);

    localparam int AW = $clog2(RAM_DEPTH);

    logic                        w_accept;
    logic                        w_we;
    logic [AW-1:0]               w_waddr;
    logic [ldsk_pkg::BYTE_W-1:0] w_wdata;
    logic                        w_re;
    logic [AW-1:0]               w_raddr_even;
    logic [AW-1:0]               w_raddr_odd;
    logic [ldsk_pkg::BYTE_W-1:0] w_rdata_even;
    logic [ldsk_pkg::BYTE_W-1:0] w_rdata_odd;
    ldsk_pkg::t_pin_req          w_req;
    logic                        w_dio_drive;
    logic                        w_dio_out;
    logic [ldsk_pkg::BYTE_W-1:0] w_seg;
    logic [ldsk_pkg::GRID_LINES-1:0] w_grid;

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    ldsk_ctrl #(
        .RAM_DEPTH  (RAM_DEPTH),
        .GRID_COUNT (GRID_COUNT)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_kind       (i_s_axis_tuser),
        .i_dio        (i_s_axis_tdata[0]),
        .i_keys       (i_s_axis_tdata[5:1]),
        .o_we         (w_we),
        .o_waddr      (w_waddr),
        .o_wdata      (w_wdata),
        .o_re         (w_re),
        .o_raddr_even (w_raddr_even),
        .o_raddr_odd  (w_raddr_odd),
        .o_req        (w_req)
    );

    ldsk_ram #(
        .WIDTH (ldsk_pkg::BYTE_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_re      (w_re),
        .i_raddr_a (w_raddr_even),
        .i_raddr_b (w_raddr_odd),
        .o_rdata_a (w_rdata_even),
        .o_rdata_b (w_rdata_odd)
    );

    ldsk_pins u_pins (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_req        (w_req),
        .i_rdata_even (w_rdata_even),
        .i_rdata_odd  (w_rdata_odd),
        .i_out_ready  (i_m_axis_tready),
        .o_in_ready   (o_s_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_dio_drive  (w_dio_drive),
        .o_dio_out    (w_dio_out),
        .o_seg        (w_seg),
        .o_grid       (w_grid)
    );

    assign o_m_axis_tdata = {2'b00, w_grid, w_seg, w_dio_out, w_dio_drive};

endmodule

`default_nettype wire

FILE: tb/sv/tb_led_driver_serial_keyscan.sv
// self-checking bench for led_driver_serial_keyscan: pin-event words in, pin-state words out
// depends on ldsk_pkg and the led_driver_serial_keyscan rtl
`default_nettype none

module tb_led_driver_serial_keyscan;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAM_DEPTH  = ldsk_pkg::RAM_DEPTH_DEF;
    localparam int GRID_COUNT = ldsk_pkg::GRID_COUNT_DEF;
    localparam int N_DIRECTED = 25;
    localparam int N_RANDOM   = 400;
    localparam int PHASE_LEN  = 60;

    typedef struct packed {
        logic [1:0] kind;
        logic       dio;
        logic [4:0] keys;
    } t_pin_event;

    typedef struct packed {
        logic       dio_drive;
        logic       dio_out;
        logic [7:0] seg;
        logic [3:0] grid;
    } t_pin_state;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data = '0;   // dio_in [0], key_lines [5:1], zero [7:6]
    logic [1:0]  s_user = '0;   // kind [1:0]
    logic        m_ready = 1'b0;
    wire         s_ready;
    wire         m_valid;
    wire  [15:0] m_data;        // dio_drive [0], dio_out [1], seg [9:2], grid [13:10]

    led_driver_serial_keyscan uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    always #2 i_clk = ~i_clk;

    t_pin_event event_q[$];
    t_pin_state pins_q[$];
    int         n_accepted = 0;
    int         n_errors = 0;
    int         n_pushed = 0;

    // shadow of the driver state
    logic [7:0]  disp_mem [16];
    logic [7:0]  shreg = '0;
    logic [4:0]  nbits = '0;
    logic [3:0]  wr_addr = '0;
    logic        addr_autoinc = 1'b0;
    logic        disp_on = 1'b0;
    int unsigned cur_grid = 0;
    logic        cmd_pending = 1'b1;
    logic        readout_on = 1'b0;
    logic [23:0] scan_word = '0;
    logic        scan_turn = 1'b0;
    logic [7:0]  seg_q = '0;
    logic [3:0]  grid_q = 4'hf;
    logic        dio_q = 1'b0;
    logic        dio_oe = 1'b0;

    function automatic logic [7:0] mem_rd(int unsigned a);
        if (a < RAM_DEPTH) return disp_mem[a];
        return 8'h00;
    endfunction

    function automatic t_pin_state apply_event(t_pin_event ev);
        logic [7:0] b;
        logic [7:0] even_b;
        logic [7:0] odd_b;
        case (ev.kind)
            ldsk_pkg::EV_STROBE: begin
                nbits = '0;
                shreg = '0;
                cmd_pending = 1'b1;
                readout_on = 1'b0;
                dio_oe = 1'b0;
            end
            ldsk_pkg::EV_CLK_RISE: begin
                if (!readout_on) begin
                    if (ev.dio) shreg[nbits[2:0]] = 1'b1;
                    nbits = nbits + 5'd1;
                    if (nbits >= 5'd8) begin
                        b = shreg;
                        if (!cmd_pending) begin
                            // data byte; out-of-range address drops it and stays put
                            if (wr_addr < RAM_DEPTH) begin
                                disp_mem[wr_addr] = b;
                                if (addr_autoinc) begin
                                    wr_addr = wr_addr + 4'd1;
                                    if (wr_addr >= RAM_DEPTH) wr_addr = '0;
                                end
                            end
                        end else begin
                            case (b[7:6])
                                ldsk_pkg::CMD_DATA: begin
                                    if (b[1]) begin
                                        readout_on = 1'b1;
                                        dio_oe = 1'b1;
                                    end
                                    addr_autoinc = !b[2];
                                    cmd_pending = 1'b0;
                                end
                                ldsk_pkg::CMD_ADDR: begin
                                    wr_addr = b[3:0];
                                    cmd_pending = 1'b0;
                                end
                                ldsk_pkg::CMD_CTRL: disp_on = b[3];
                                default: ;
                            endcase
                        end
                        nbits = '0;
                        shreg = '0;
                    end
                end
            end
            ldsk_pkg::EV_CLK_FALL: begin
                if (readout_on && nbits < 5'd24) begin
                    dio_q = scan_word[nbits];
                    nbits = nbits + 5'd1;
                end
            end
            default: begin
                if (scan_turn) begin
                    grid_q = 4'hf;
                    scan_word = '0;
                    scan_word[1]  = ev.keys[0];
                    scan_word[4]  = ev.keys[1];
                    scan_word[9]  = ev.keys[2];
                    scan_word[12] = ev.keys[3];
                    scan_word[17] = ev.keys[4];
                    seg_q = (seg_q & 8'he0) | 8'h0f;
                    scan_turn = 1'b0;
                end else begin
                    if (disp_on) begin
                        // 5+3 mapping: low five bits of even byte, bits 5:3 of odd byte
                        even_b = mem_rd(cur_grid * 2);
                        odd_b = mem_rd(cur_grid * 2 + 1);
                        seg_q = {odd_b[5:3], even_b[4:0]};
                        if (cur_grid < ldsk_pkg::GRID_LINES)
                            grid_q = grid_q & ~(4'b1 << cur_grid);
                        cur_grid = (cur_grid + 1) % GRID_COUNT;
                    end
                    scan_turn = 1'b1;
                end
            end
        endcase
        return '{dio_drive: dio_oe, dio_out: dio_q, seg: seg_q, grid: grid_q};
    endfunction

    // idle / stall rates per phase: none, sender 75, receiver 75, both 7
    function automatic int send_idle_pct(int n);
        case ((n / PHASE_LEN) % 4)
            1: return 75;
            3: return 7;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct(int n);
        case ((n / PHASE_LEN) % 4)
            2: return 75;
            3: return 7;
            default: return 0;
        endcase
    endfunction

    // driver: predicts each accepted word, then presents the next one
    always @(posedge i_clk) begin
        t_pin_event nxt;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                pins_q.push_back(apply_event('{kind: s_user, dio: s_data[0],
                                               keys: s_data[5:1]}));
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (event_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct(n_accepted)) begin
                    nxt = event_q.pop_front();
                    s_data <= {2'b00, nxt.keys, nxt.dio};
                    s_user <= nxt.kind;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result word against the oldest predicted pin state
    always @(posedge i_clk) begin
        t_pin_state want;
        t_pin_state got;
        if (i_rst_n) begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct(n_accepted));
            if (m_valid && m_ready) begin
                got = '{dio_drive: m_data[0], dio_out: m_data[1], seg: m_data[9:2],
                        grid: m_data[13:10]};
                if (pins_q.size() == 0) begin
                    if (n_errors < 10) $display("unexpected word %h", m_data);
                    n_errors++;
                end else begin
                    want = pins_q.pop_front();
                    if (got.dio_drive !== want.dio_drive || got.dio_out !== want.dio_out ||
                        got.seg !== want.seg || got.grid !== want.grid) begin
                        if (n_errors < 10)
                            $display("mismatch: drive %b/%b dio %b/%b seg %h/%h grid %h/%h",
                                     want.dio_drive, got.dio_drive, want.dio_out, got.dio_out,
                                     want.seg, got.seg, want.grid, got.grid);
                        n_errors++;
                    end
                end
            end
        end
    end

    task automatic push_word(logic [1:0] kind, logic dio);
        event_q.push_back('{kind: kind, dio: dio, keys: 5'($urandom_range(0, 31))});
        n_pushed++;
    endtask

    task automatic push_noise_tick();
        if ($urandom_range(0, 9) == 0) push_word(ldsk_pkg::EV_TICK, 1'($urandom));
    endtask

    task automatic send_byte(logic [7:0] b);
        for (int i = 0; i < 8; i++) begin
            push_word(ldsk_pkg::EV_CLK_RISE, b[i]);
            if ($urandom_range(0, 3) == 0) push_word(ldsk_pkg::EV_CLK_FALL, 1'($urandom));
            push_noise_tick();
        end
    endtask

    initial begin
        int nbytes;
        int nfalls;
        for (int i = 0; i < 16; i++) disp_mem[i] = '0;

        // directed: refresh while off, scan with all keys, fall outside readout,
        // display on, key read with a rise ignored during readout
        event_q.push_back('{kind: ldsk_pkg::EV_TICK, dio: 1'b0, keys: 5'h00});
        event_q.push_back('{kind: ldsk_pkg::EV_TICK, dio: 1'b1, keys: 5'h1f});
        event_q.push_back('{kind: ldsk_pkg::EV_CLK_FALL, dio: 1'b0, keys: 5'h00});
        event_q.push_back('{kind: ldsk_pkg::EV_STROBE, dio: 1'b0, keys: 5'h00});
        for (int i = 0; i < 8; i++)
            event_q.push_back('{kind: ldsk_pkg::EV_CLK_RISE,
                                dio: 1'({ldsk_pkg::CMD_CTRL, 6'h0f} >> i), keys: 5'h00});
        event_q.push_back('{kind: ldsk_pkg::EV_STROBE, dio: 1'b0, keys: 5'h00});
        for (int i = 0; i < 8; i++)
            event_q.push_back('{kind: ldsk_pkg::EV_CLK_RISE,
                                dio: 1'({ldsk_pkg::CMD_DATA, 6'h02} >> i), keys: 5'h1f});
        event_q.push_back('{kind: ldsk_pkg::EV_CLK_RISE, dio: 1'b1, keys: 5'h00});
        event_q.push_back('{kind: ldsk_pkg::EV_CLK_FALL, dio: 1'b0, keys: 5'h00});
        event_q.push_back('{kind: ldsk_pkg::EV_CLK_FALL, dio: 1'b1, keys: 5'h00});
        event_q.push_back('{kind: ldsk_pkg::EV_STROBE, dio: 1'b0, keys: 5'h00});

        // random: mostly well-formed transactions with random content
        while (n_pushed < N_RANDOM - N_DIRECTED) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    push_word(ldsk_pkg::EV_STROBE, 1'($urandom));
                    send_byte({ldsk_pkg::CMD_DATA, 6'($urandom) & 6'h3d});
                    push_word(ldsk_pkg::EV_STROBE, 1'($urandom));
                    send_byte({ldsk_pkg::CMD_ADDR, 2'($urandom), 4'($urandom_range(0, 15))});
                    nbytes = $urandom_range(1, 4);
                    for (int i = 0; i < nbytes; i++) send_byte(8'($urandom));
                end
                4: begin
                    push_word(ldsk_pkg::EV_STROBE, 1'($urandom));
                    send_byte({ldsk_pkg::CMD_CTRL, 2'($urandom), ($urandom_range(0, 4) != 0),
                               3'($urandom)});
                end
                5, 6: begin
                    push_word(ldsk_pkg::EV_TICK, 1'($urandom));
                    push_word(ldsk_pkg::EV_TICK, 1'($urandom));
                    push_word(ldsk_pkg::EV_STROBE, 1'($urandom));
                    send_byte({ldsk_pkg::CMD_DATA, 6'($urandom) | 6'h02});
                    nfalls = $urandom_range(20, 30);
                    for (int i = 0; i < nfalls; i++) begin
                        push_word(ldsk_pkg::EV_CLK_FALL, 1'($urandom));
                        if ($urandom_range(0, 7) == 0)
                            push_word(ldsk_pkg::EV_CLK_RISE, 1'($urandom));
                        push_noise_tick();
                    end
                    push_word(ldsk_pkg::EV_STROBE, 1'($urandom));
                end
                7: begin
                    push_word(ldsk_pkg::EV_STROBE, 1'($urandom));
                    send_byte({ldsk_pkg::CMD_MODE, 6'($urandom)});
                end
                8: begin
                    nbytes = $urandom_range(2, 8);
                    for (int i = 0; i < nbytes; i++) push_word(ldsk_pkg::EV_TICK, 1'($urandom));
                end
                default: begin
                    nbytes = $urandom_range(1, 6);
                    for (int i = 0; i < nbytes; i++)
                        push_word(2'($urandom_range(0, 3)), 1'($urandom));
                end
            endcase
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (event_q.size() > 0 || s_valid || pins_q.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (n_errors == 0 && pins_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #500us;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
